// ===== design/pfbc_pkg.sv =====
// Shared types and constants for the point frustum and backface cull unit.
package pfbc_pkg;

   localparam int CoefW = 16;
   localparam int RowW = 64;
   localparam int DirW = 48;
   localparam int CsrIdxW = 3;
   localparam int ClipW = 35;
   localparam int DotW = 34;
   localparam int IndexW = 16;

   localparam logic [CsrIdxW-1:0] CSR_MATRIX_ROW_0 = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_MATRIX_ROW_1 = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_MATRIX_ROW_2 = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_MATRIX_ROW_3 = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_VIEW_DIRECTION = 3'd4;

   localparam logic [RowW-1:0] ROW_0_RESET = 64'h0000_0000_0000_0800;
   localparam logic [RowW-1:0] ROW_1_RESET = 64'h0000_0000_0800_0000;
   localparam logic [RowW-1:0] ROW_2_RESET = 64'h0000_0800_0000_0000;
   localparam logic [RowW-1:0] ROW_3_RESET = 64'h0800_0000_0000_0000;
   localparam logic [DirW-1:0] VIEW_DIR_RESET = 48'hC000_0000_0000;

   localparam logic [1:0] KEEP_FACING = 2'd0;
   localparam logic [1:0] KEEP_VISIBLE = 2'd1;
   localparam logic [1:0] KEEP_FIRST = 2'd2;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic               last_point;
   } pfbc_req_type;

   typedef struct packed {
      logic [15:0] point_index;
      logic        in_view;
      logic        faces_camera;
      logic        cloud_done;
      logic [1:0]  keep_set;
   } pfbc_rsp_type;

   typedef struct packed {
      logic [3:0][RowW-1:0] matrix_row;
      logic [DirW-1:0]      view_dir;
   } pfbc_cfg_type;

   typedef struct packed {
      logic visible;
      logic facing;
   } pfbc_flags_type;

endpackage

// ===== design/pfbc_clip_test.sv =====
// Clip-space transform, division-free clip cube test and normal facing test.
module pfbc_clip_test (
   input  pfbc_pkg::pfbc_cfg_type   cfg,
   input  pfbc_pkg::pfbc_req_type   point,
   output pfbc_pkg::pfbc_flags_type flags
);

   logic signed [15:0] pos [3];
   logic signed [15:0] norm [3];
   logic signed [15:0] coef [4][4];
   logic signed [15:0] dir [3];
   logic signed [31:0] prod [4][3];
   logic signed [31:0] dprod [3];
   logic signed [pfbc_pkg::ClipW-1:0] clip [4];
   logic [pfbc_pkg::ClipW-1:0] clip_mag [4];
   logic signed [pfbc_pkg::DotW-1:0] dot;
   logic in_cube;

   assign pos[0] = point.pos_x;
   assign pos[1] = point.pos_y;
   assign pos[2] = point.pos_z;
   assign norm[0] = point.norm_x;
   assign norm[1] = point.norm_y;
   assign norm[2] = point.norm_z;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 4; k++) begin
            coef[r][k] = cfg.matrix_row[r][16*k +: 16];
         end
      end
      for (int k = 0; k < 3; k++) begin
         dir[k] = cfg.view_dir[16*k +: 16];
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod[r][k] = coef[r][k] * pos[k];
         end
         clip[r] = pfbc_pkg::ClipW'(coef[r][3]) + pfbc_pkg::ClipW'(prod[r][0])
                 + pfbc_pkg::ClipW'(prod[r][1]) + pfbc_pkg::ClipW'(prod[r][2]);
         clip_mag[r] = clip[r][pfbc_pkg::ClipW-1] ? pfbc_pkg::ClipW'(-clip[r])
                                                  : pfbc_pkg::ClipW'(clip[r]);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dprod[k] = dir[k] * norm[k];
      end
      dot = pfbc_pkg::DotW'(dprod[0]) + pfbc_pkg::DotW'(dprod[1])
          + pfbc_pkg::DotW'(dprod[2]);
   end

   // |x|,|y|,|z| <= |w| with w nonzero
   assign in_cube = (clip[3] != '0)
                 && (clip_mag[0] <= clip_mag[3])
                 && (clip_mag[1] <= clip_mag[3])
                 && (clip_mag[2] <= clip_mag[3]);

   assign flags.visible = in_cube;
   assign flags.facing = in_cube && dot[pfbc_pkg::DotW-1];

endmodule

// ===== design/pfbc_cloud_track.sv =====
// Per-cloud point counter, visibility flags and keep-set decision.
module pfbc_cloud_track #(
   parameter int MAX_POINTS = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     last_point,
   input  pfbc_pkg::pfbc_flags_type flags,
   output logic [15:0]              point_index,
   output logic [1:0]               keep_set
);

   localparam int CntW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            any_vis_ff, any_vis_in;
   logic            any_face_ff, any_face_in;
   logic            seen_vis;
   logic            seen_face;

   assign seen_vis = any_vis_ff || flags.visible;
   assign seen_face = any_face_ff || flags.facing;

   always_comb begin
      cnt_in = cnt_ff;
      any_vis_in = any_vis_ff;
      any_face_in = any_face_ff;
      if (advance) begin
         if (last_point) begin
            cnt_in = '0;
            any_vis_in = 1'b0;
            any_face_in = 1'b0;
         end else begin
            cnt_in = (cnt_ff == CntW'(MAX_POINTS - 1)) ? '0 : cnt_ff + 1'b1;
            any_vis_in = seen_vis;
            any_face_in = seen_face;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         any_vis_ff <= 1'b0;
         any_face_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         any_vis_ff <= any_vis_in;
         any_face_ff <= any_face_in;
      end
   end

   assign point_index = 16'(cnt_ff);

   always_comb begin
      keep_set = pfbc_pkg::KEEP_FACING;
      if (last_point) begin
         if (seen_face) begin
            keep_set = pfbc_pkg::KEEP_FACING;
         end else if (seen_vis) begin
            keep_set = pfbc_pkg::KEEP_VISIBLE;
         end else begin
            keep_set = pfbc_pkg::KEEP_FIRST;
         end
      end
   end

endmodule

// ===== design/point_frustum_backface_cull_unit.sv =====
// Top level of the point frustum and backface cull unit.
// Each point beat is registered, transformed by the 4x4 matrix and tested against
// the clip cube and the view direction in one pass, and the result is registered;
// a new point is taken every cycle unless a result stalls. While one stalls, one more
// point can wait in the input register before req_ready drops. The user must write
// matrix rows and the view direction through the csr_ port only while no point is
// in flight; the block itself does not enforce this.
module point_frustum_backface_cull_unit #(
   parameter int MAX_POINTS = 65536
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pfbc_pkg::pfbc_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pfbc_pkg::pfbc_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [pfbc_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [pfbc_pkg::RowW-1:0]          csr_wdata
);

   pfbc_pkg::pfbc_cfg_type   cfg_ff, cfg_in;
   pfbc_pkg::pfbc_req_type   pnt_ff;
   logic                     pnt_valid_ff, pnt_valid_in;
   pfbc_pkg::pfbc_rsp_type   rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   pfbc_pkg::pfbc_flags_type flags;
   logic                     out_open;
   logic                     advance;
   logic [15:0]              point_index;
   logic [1:0]               keep_set;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pfbc_pkg::CSR_MATRIX_ROW_0: cfg_in.matrix_row[0] = csr_wdata;
            pfbc_pkg::CSR_MATRIX_ROW_1: cfg_in.matrix_row[1] = csr_wdata;
            pfbc_pkg::CSR_MATRIX_ROW_2: cfg_in.matrix_row[2] = csr_wdata;
            pfbc_pkg::CSR_MATRIX_ROW_3: cfg_in.matrix_row[3] = csr_wdata;
            pfbc_pkg::CSR_VIEW_DIRECTION: cfg_in.view_dir = csr_wdata[pfbc_pkg::DirW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.matrix_row[0] <= pfbc_pkg::ROW_0_RESET;
         cfg_ff.matrix_row[1] <= pfbc_pkg::ROW_1_RESET;
         cfg_ff.matrix_row[2] <= pfbc_pkg::ROW_2_RESET;
         cfg_ff.matrix_row[3] <= pfbc_pkg::ROW_3_RESET;
         cfg_ff.view_dir <= pfbc_pkg::VIEW_DIR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign out_open = !rsp_valid_ff || rsp_ready;
   assign advance = pnt_valid_ff && out_open;
   assign req_ready = !pnt_valid_ff || out_open;

   assign pnt_valid_in = (req_valid && req_ready) || (pnt_valid_ff && !out_open);

   always_ff @(posedge clock) begin
      if (reset) begin
         pnt_valid_ff <= 1'b0;
      end else begin
         pnt_valid_ff <= pnt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pnt_ff <= req_data;
      end
   end

   pfbc_clip_test u_clip_test (
      .cfg   (cfg_ff),
      .point (pnt_ff),
      .flags (flags)
   );

   pfbc_cloud_track #(
      .MAX_POINTS (MAX_POINTS)
   ) u_cloud_track (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .last_point  (pnt_ff.last_point),
      .flags       (flags),
      .point_index (point_index),
      .keep_set    (keep_set)
   );

   always_comb begin
      rsp_in.point_index = point_index;
      rsp_in.in_view = flags.visible;
      rsp_in.faces_camera = flags.facing;
      rsp_in.cloud_done = pnt_ff.last_point;
      rsp_in.keep_set = keep_set;
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
